// ===== sv/bb3_pkg.sv =====
// shared constants, item types and the reciprocal table of the 3x3 box blur
package bb3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int ROW_W      = HEIGHT_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int POS_W      = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd768;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic             emit;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic [CNT_W-1:0] cnt;
    logic             frame_end;
  } ctl_t;

  typedef struct packed {
    rgb_t             pix;
    logic [COL_W-1:0] col;
    ctl_t             ctl;
  } cmd_t;

  typedef struct packed {
    rgb_t pix;
    logic frame_end;
  } res_t;

  // ceil(2^16 / n): exact rounding for sums up to 9 * 255 + 4
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd5:    m = 17'd13108;
      4'd6:    m = 17'd10923;
      4'd7:    m = 17'd9363;
      4'd8:    m = 17'd8192;
      4'd9:    m = 17'd7282;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/bb3_front.sv =====
// front end: frame registers, position counters and item classification
module bb3_front import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  logic                  in_action,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cmd_push,
  output cmd_t                  cmd_data
);

  logic [WIDTH_W-1:0]  width_r,   width_nxt;
  logic [HEIGHT_W-1:0] height_r,  height_nxt;
  logic [ROW_W-1:0]    in_row_r,  in_row_nxt;
  logic [COL_W-1:0]    in_col_r,  in_col_nxt;
  logic [HEIGHT_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;

  logic               accept, draining, take, emit, last;
  logic [POS_W-1:0]   width_ext, in_col_inc, out_col_inc;
  logic [ROW_W-1:0]   out_row_inc, height_ext;
  logic               top_ok, bot_ok, left_ok, right_ok;
  logic [1:0]         rows, cols;
  logic [WIDTH_W-1:0] w_wr;
  logic [HEIGHT_W-1:0] h_wr;

  always_comb begin
    accept      = push && !full;
    height_ext  = ROW_W'(height_r);
    width_ext   = POS_W'(width_r);
    draining    = in_row_r >= height_ext;
    // items of the wrong kind for the current phase are dropped
    take        = accept && ((in_action == ACT_DRAIN) == draining);
    emit        = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && in_col_r != '0);
    in_col_inc  = POS_W'(in_col_r) + POS_W'(1);
    out_col_inc = POS_W'(out_col_r) + POS_W'(1);
    out_row_inc = ROW_W'(out_row_r) + ROW_W'(1);
    last        = (out_row_inc >= height_ext) && (out_col_inc >= width_ext);

    top_ok   = out_row_r != '0;
    bot_ok   = out_row_inc < height_ext;
    left_ok  = out_col_r != '0;
    // a result emitted at column zero belongs to the end of the previous row
    right_ok = (out_col_inc < width_ext) && (in_col_r != '0);
    rows     = 2'd1 + 2'(top_ok) + 2'(bot_ok);
    cols     = 2'd1 + 2'(left_ok) + 2'(right_ok);

    cmd_push               = take;
    cmd_data.pix.red       = (in_action == ACT_PIXEL) ? in_red   : '0;
    cmd_data.pix.green     = (in_action == ACT_PIXEL) ? in_green : '0;
    cmd_data.pix.blue      = (in_action == ACT_PIXEL) ? in_blue  : '0;
    cmd_data.col           = in_col_r;
    cmd_data.ctl.emit      = emit;
    cmd_data.ctl.top_ok    = top_ok;
    cmd_data.ctl.bot_ok    = bot_ok;
    cmd_data.ctl.left_ok   = left_ok;
    cmd_data.ctl.right_ok  = right_ok;
    cmd_data.ctl.cnt       = CNT_W'({2'b00, rows} * {2'b00, cols});
    cmd_data.ctl.frame_end = last;

    w_wr = cfg_data[WIDTH_W-1:0];
    if (w_wr == '0) begin
      w_wr = WIDTH_W'(1);
    end else if (int'(w_wr) > MAX_WIDTH) begin
      w_wr = WIDTH_W'(MAX_WIDTH);
    end
    h_wr = cfg_data[HEIGHT_W-1:0];
    if (h_wr == '0) begin
      h_wr = HEIGHT_W'(1);
    end

    width_nxt   = width_r;
    height_nxt  = height_r;
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = w_wr;
        REG_FRAME_HEIGHT: height_nxt = h_wr;
        default: ;
      endcase
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (take) begin
      if (in_col_inc >= width_ext) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (emit) begin
        if (out_col_inc >= width_ext) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HEIGHT_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
        if (last) begin
          in_row_nxt  = '0;
          in_col_nxt  = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

endmodule

// ===== sv/bb3_cmd_fifo.sv =====
// short queue of classified items between the front end and the blur datapath
module bb3_cmd_fifo import bb3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t                  slot_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] count_r, count_nxt;
  logic                  do_wr, do_rd;

  always_comb begin
    full       = count_r == CMDQ_CNT_W'(CMDQ_DEPTH);
    empty      = count_r == '0;
    do_wr      = wr_en && !full;
    do_rd      = rd_en && !empty;
    rd_data    = slot_r[rd_ptr_r];
    wr_ptr_nxt = do_wr ? wr_ptr_r + CMDQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + CMDQ_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CMDQ_CNT_W'(do_wr) - CMDQ_CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/bb3_back.sv =====
// blur datapath: line stores, 3x3 window, masked sums and reciprocal divide
module bb3_back import bb3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_empty,
  output logic cmd_pop,
  input  cmd_t cmd_data,
  input  logic res_full,
  output logic res_push,
  output res_t res_data
);

  logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];

  logic             adv;
  logic             mem_we;

  // stage 1: popped item and line store read
  logic             s1_valid_r;
  cmd_t             s1_cmd_r;
  logic [PIX_W-1:0] rd_prev_r, rd_older_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_prev_r, fwd_older_r;
  logic [PIX_W-1:0] prev_eff, older_eff;
  logic             fwd_nxt;

  // stage 2: shifted window
  logic             s2_valid_r;
  ctl_t             s2_ctl_r;
  logic [PIX_W-1:0] win_r [3][3];
  logic [2:0]       row_ok, col_ok;

  // stage 3: masked sums
  logic             s3_valid_r;
  ctl_t             s3_ctl_r;
  logic [SUM_W-1:0] s3_sum_r [3];
  logic [SUM_W-1:0] sum_nxt  [3];

  // stage 4: products with the reciprocal
  logic              s4_valid_r;
  logic              s4_emit_r;
  logic              s4_fe_r;
  logic [PROD_W-1:0] s4_prod_r [3];
  logic [RECIP_W-1:0] m;

  always_comb begin
    adv      = !(s4_valid_r && s4_emit_r && res_full);
    cmd_pop  = adv && !cmd_empty;
    mem_we   = adv && s1_valid_r;
    // same column as the item leaving stage 1: its store write is not visible yet
    fwd_nxt  = cmd_pop && s1_valid_r && (cmd_data.col == s1_cmd_r.col);
    prev_eff  = fwd_r ? fwd_prev_r  : rd_prev_r;
    older_eff = fwd_r ? fwd_older_r : rd_older_r;

    row_ok = {s2_ctl_r.bot_ok, 1'b1, s2_ctl_r.top_ok};
    col_ok = {s2_ctl_r.right_ok, 1'b1, s2_ctl_r.left_ok};
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          sum_nxt[0] = sum_nxt[0] + SUM_W'(win_r[i][j][3*CH_W-1:2*CH_W]);
          sum_nxt[1] = sum_nxt[1] + SUM_W'(win_r[i][j][2*CH_W-1:CH_W]);
          sum_nxt[2] = sum_nxt[2] + SUM_W'(win_r[i][j][CH_W-1:0]);
        end
      end
    end

    m = recip(s3_ctl_r.cnt);

    res_push           = s4_valid_r && s4_emit_r && !res_full;
    res_data.pix.red   = s4_prod_r[0][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    res_data.pix.green = s4_prod_r[1][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    res_data.pix.blue  = s4_prod_r[2][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    res_data.frame_end = s4_fe_r;
  end

  // line stores
  always_ff @(posedge clk) begin
    if (mem_we) begin
      prev_mem[s1_cmd_r.col]  <= s1_cmd_r.pix;
      older_mem[s1_cmd_r.col] <= prev_eff;
    end
    if (cmd_pop) begin
      rd_prev_r  <= prev_mem[cmd_data.col];
      rd_older_r <= older_mem[cmd_data.col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= cmd_pop;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      fwd_r      <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cmd_pop) begin
        s1_cmd_r    <= cmd_data;
        fwd_prev_r  <= s1_cmd_r.pix;
        fwd_older_r <= prev_eff;
      end
      if (s1_valid_r) begin
        s2_ctl_r <= s1_cmd_r.ctl;
        for (int k = 0; k < 3; k++) begin
          win_r[k][0] <= win_r[k][1];
          win_r[k][1] <= win_r[k][2];
        end
        win_r[0][2] <= older_eff;
        win_r[1][2] <= prev_eff;
        win_r[2][2] <= s1_cmd_r.pix;
      end
      s3_ctl_r <= s2_ctl_r;
      for (int c = 0; c < 3; c++) begin
        s3_sum_r[c]  <= sum_nxt[c];
        // round half up: add half the count before scaling
        s4_prod_r[c] <= PROD_W'(s3_sum_r[c] + SUM_W'(s3_ctl_r.cnt >> 1)) * PROD_W'(m);
      end
      s4_emit_r <= s3_ctl_r.emit;
      s4_fe_r   <= s3_ctl_r.frame_end;
    end
  end

endmodule

// ===== sv/bb3_res_fifo.sv =====
// result queue feeding the output ports
module bb3_res_fifo import bb3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  res_t wr_data,
  output logic full,
  input  logic rd_en,
  output res_t rd_data,
  output logic empty
);

  res_t                  slot_r [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RESQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RESQ_CNT_W-1:0] count_r, count_nxt;
  logic                  do_wr, do_rd;

  always_comb begin
    full       = count_r == RESQ_CNT_W'(RESQ_DEPTH);
    empty      = count_r == '0;
    do_wr      = wr_en && !full;
    do_rd      = rd_en && !empty;
    rd_data    = slot_r[rd_ptr_r];
    wr_ptr_nxt = do_wr ? wr_ptr_r + RESQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + RESQ_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + RESQ_CNT_W'(do_wr) - RESQ_CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/box_blur_3x3_rgb_unit.sv =====
// streaming 3x3 box blur over rgb frames in raster order. Each output channel is the
// rounded-half-up mean of the in-frame neighbours (edges skip, not pad). Results trail
// the input by one row plus one pixel; after a frame's last pixel, frame_width + 1
// drain items (frame_width + 1 also for a single-row frame, the first giving nothing)
// push out the rest, and the last result carries frame_end. Items of the wrong kind
// for the phase (pixels while draining, drains mid-frame) are taken and dropped. The
// block takes one item per clock sustained while the result queue has room; a result
// enters the output queue after its item has passed the command queue and the
// four-stage datapath (line store read, window shift, sum, reciprocal multiply). The
// line stores need no clearing pass. Writing either frame register restarts the frame.
module box_blur_3x3_rgb_unit import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_action,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  output logic                  empty,
  input  logic                  pop,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic                  out_frame_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_wr, cmd_rd;
  logic res_push, res_full;
  res_t res_wr, res_rd;

  bb3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (cmd_full),
    .in_action (in_action),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wr)
  );

  bb3_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  bb3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_rd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wr)
  );

  bb3_res_fifo u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign full          = cmd_full;
  assign out_red       = res_rd.pix.red;
  assign out_green     = res_rd.pix.green;
  assign out_blue      = res_rd.pix.blue;
  assign out_frame_end = res_rd.frame_end;

endmodule
